// ===== rtl/qesc_pkg.sv =====
// ----------------------------------------------------------------------------
// qesc_pkg: shared types and constants of the four-channel ESC pulse generator
// Item modes, register indexes, widths and reset values used by the top level
// and the per-motor channel.
// ----------------------------------------------------------------------------
package qesc_pkg;

  localparam int unsigned MotorCount  = 4;
  localparam int unsigned ValueFields = 4;
  localparam int unsigned TickWidth   = 16;
  localparam int unsigned RegWidth    = 16;
  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned TargetWidth = 3;
  localparam int unsigned CfgAddrWidth = 2;

  localparam logic [RegWidth-1:0] PeriodTicksReset = RegWidth'(6000);
  localparam logic [RegWidth-1:0] MinTicksReset    = RegWidth'(1500);
  localparam logic [RegWidth-1:0] MaxTicksReset    = RegWidth'(3000);

  // Stop target that addresses every motor at once
  localparam logic [TargetWidth-1:0] StopAll = TargetWidth'(4);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_ALTER = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_PERIOD_TICKS = 2'd0,
    REG_MIN_TICKS    = 2'd1,
    REG_MAX_TICKS    = 2'd2
  } cfg_reg_e;

  // Controls shared by all channels for the item being processed
  typedef struct packed {
    logic                 advance;
    mode_e                mode;
    logic                 wrap;
    logic [TickWidth-1:0] count;
  } chan_ctrl_t;

endpackage

// ===== rtl/qesc_chan.sv =====
// ----------------------------------------------------------------------------
// qesc_chan: one motor channel
// Holds the setpoint, the active compare and the pulse level of one motor and
// works out their next values for the item at the head of the pipeline.
// ----------------------------------------------------------------------------
module qesc_chan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qesc_pkg::chan_ctrl_t             ctrl_i,
  input  logic                             stop_hit_i,
  input  logic                             has_value_i,
  input  logic [qesc_pkg::ValueWidth-1:0]  value_i,
  input  logic [qesc_pkg::RegWidth-1:0]    min_ticks_i,
  input  logic [qesc_pkg::RegWidth-1:0]    max_ticks_i,
  output logic                             level_d_o,
  output logic [qesc_pkg::RegWidth-1:0]    speed_d_o
);
  import qesc_pkg::*;

  localparam int unsigned TopWidth = RegWidth + 1;
  localparam int unsigned SumWidth = RegWidth + 2;
  localparam int unsigned CmpWidth = (TickWidth > RegWidth) ? TickWidth : RegWidth;

  logic [RegWidth-1:0] setpoint_q, setpoint_d;
  logic [RegWidth-1:0] compare_q, compare_d;
  logic                level_q, level_d;

  logic signed [TopWidth-1:0] top;
  logic signed [TopWidth-1:0] speed_ext;
  logic signed [SumWidth-1:0] sum;
  logic [RegWidth:0]          set_sum;
  logic                       is_minus_one;

  assign top          = $signed({1'b0, max_ticks_i}) - $signed({1'b0, min_ticks_i});
  assign speed_ext    = $signed({1'b0, value_i});
  assign sum          = $signed({2'b00, setpoint_q}) + SumWidth'($signed(value_i));
  assign set_sum      = {1'b0, value_i} + {1'b0, min_ticks_i};
  assign is_minus_one = (value_i == '1);

  always_comb begin
    setpoint_d = setpoint_q;
    compare_d  = compare_q;
    level_d    = level_q;
    case (ctrl_i.mode)
      MODE_TICK: begin
        if (ctrl_i.wrap) begin
          compare_d = setpoint_q;
          level_d   = 1'b1;
        end
        if (CmpWidth'(compare_d) == CmpWidth'(ctrl_i.count)) begin
          level_d = 1'b0;
        end
      end
      MODE_SET: begin
        if (has_value_i && !is_minus_one) begin
          if (value_i[ValueWidth-1]) begin
            setpoint_d = min_ticks_i;
          end else if (speed_ext > top) begin
            setpoint_d = max_ticks_i;
          end else begin
            setpoint_d = set_sum[RegWidth-1:0];
          end
        end
      end
      MODE_ALTER: begin
        if (has_value_i && (value_i != '0)) begin
          if (sum < $signed({2'b00, min_ticks_i})) begin
            setpoint_d = min_ticks_i;
          end else if (sum > $signed({2'b00, max_ticks_i})) begin
            setpoint_d = max_ticks_i;
          end else begin
            setpoint_d = sum[RegWidth-1:0];
          end
        end
      end
      MODE_STOP: begin
        if (stop_hit_i) begin
          setpoint_d = min_ticks_i;
        end
      end
      default: begin
        setpoint_d = setpoint_q;
      end
    endcase
  end

  assign level_d_o = level_d;
  assign speed_d_o = setpoint_d - min_ticks_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= MinTicksReset;
      compare_q  <= MinTicksReset;
      level_q    <= 1'b1;
    end else if (ctrl_i.advance) begin
      setpoint_q <= setpoint_d;
      compare_q  <= compare_d;
      level_q    <= level_d;
    end
  end

endmodule

// ===== rtl/quad_esc_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// quad_esc_pulse_generator: four-channel hobby-ESC pulse generator
// Period counter, per-motor compare and setpoint logic behind a stream input
// and a stream output, one result item for every input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel. tuser carries the mode (tick,
//   set speeds, alter speeds, stop); tdata carries the four signed values and
//   the stop target. Each item yields exactly one result item on m_axis with
//   the pin levels, the period-start flag and the four speeds (setpoint minus
//   min_ticks) as they stand after that item.
//   Configuration (period, min and max ticks) is written through cfg_we_i,
//   cfg_addr_i and cfg_wdata_i; the user must write it only while no item
//   is in flight; the block itself does not enforce this. The item passes
//   through the input register and then the result register; a stall holds
//   it in the input register until the result slot is free.
//   Throughput: one item per cycle while m_axis_tready_i is high; the channel
//   update is a single pass of add, clamp and compare logic between registers.
//   Stall: while m_axis_tready_i is low the result holds, the input register
//   fills and then s_axis_tready_o drops; no item is lost or repeated.
//   Reset: counter to zero, all pins high, setpoints and compares to the
//   reset value of min_ticks, registers to their reset values.
// ----------------------------------------------------------------------------
module quad_esc_pulse_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [qesc_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [qesc_pkg::RegWidth-1:0]       cfg_wdata_i,
  // input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // value_a[15:0], value_b[31:16], value_c[47:32], value_d[63:48],
  // stop_target[66:64], zero fill
  input  logic [71:0]                         s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]                          s_axis_tuser_i,
  // result items
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // pin_levels[3:0], period_start[4], speed_a[20:5], speed_b[36:21],
  // speed_c[52:37], speed_d[68:53], zero fill
  output logic [71:0]                         m_axis_tdata_o
);
  import qesc_pkg::*;

  localparam int unsigned CmpWidth = (TickWidth > RegWidth) ? TickWidth : RegWidth;

  // configuration registers
  logic [RegWidth-1:0] period_ticks_q, min_ticks_q, max_ticks_q;

  // input register
  logic                                    in_valid_q;
  mode_e                                   mode_q;
  logic [ValueFields-1:0][ValueWidth-1:0]  values_q;
  logic [TargetWidth-1:0]                  target_q;

  // period counter
  logic [TickWidth-1:0] count_q, count_inc, count_next;
  logic                 wrap;

  // result register
  logic                                    out_valid_q;
  logic [ValueFields-1:0]                  pins_q, pins_d;
  logic                                    start_q;
  logic [ValueFields-1:0][RegWidth-1:0]    speeds_q, speeds_d;

  logic                                    advance;
  logic                                    s_accept;
  chan_ctrl_t                              ctrl;
  logic [MotorCount-1:0]                   levels_d;
  logic [MotorCount-1:0][RegWidth-1:0]     chan_speed;

  // Move the held item into the result register when the result slot is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks_q <= PeriodTicksReset;
      min_ticks_q    <= MinTicksReset;
      max_ticks_q    <= MaxTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PERIOD_TICKS: period_ticks_q <= cfg_wdata_i;
        REG_MIN_TICKS:    min_ticks_q    <= cfg_wdata_i;
        REG_MAX_TICKS:    max_ticks_q    <= cfg_wdata_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Input register: load on acceptance, drop once the item has moved on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      mode_q   <= mode_e'(s_axis_tuser_i);
      values_q <= s_axis_tdata_i[ValueFields*ValueWidth-1:0];
      target_q <= s_axis_tdata_i[ValueFields*ValueWidth +: TargetWidth];
    end
  end

  // Period counter: wrap on overflow or once the period is reached
  assign count_inc  = count_q + TickWidth'(1);
  assign wrap       = (mode_q == MODE_TICK) &&
                      ((count_inc == '0) || (CmpWidth'(count_inc) >= CmpWidth'(period_ticks_q)));
  assign count_next = wrap ? '0 : count_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance && (mode_q == MODE_TICK)) begin
      count_q <= count_next;
    end
  end

  assign ctrl.advance = advance;
  assign ctrl.mode    = mode_q;
  assign ctrl.wrap    = wrap;
  assign ctrl.count   = count_next;

  for (genvar i = 0; i < MotorCount; i++) begin : g_chan
    logic                  stop_hit;
    logic                  has_value;
    logic [ValueWidth-1:0] value;

    assign stop_hit = (target_q == StopAll) || (target_q == TargetWidth'(i));
    if (i < ValueFields) begin : g_val
      assign has_value = 1'b1;
      assign value     = values_q[i];
    end else begin : g_noval
      assign has_value = 1'b0;
      assign value     = '0;
    end

    qesc_chan u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .stop_hit_i  (stop_hit),
      .has_value_i (has_value),
      .value_i     (value),
      .min_ticks_i (min_ticks_q),
      .max_ticks_i (max_ticks_q),
      .level_d_o   (levels_d[i]),
      .speed_d_o   (chan_speed[i])
    );
  end

  // Only the first four motors appear in the result; absent ones read zero
  for (genvar i = 0; i < ValueFields; i++) begin : g_out
    if (i < MotorCount) begin : g_on
      assign pins_d[i]   = levels_d[i];
      assign speeds_d[i] = chan_speed[i];
    end else begin : g_off
      assign pins_d[i]   = 1'b0;
      assign speeds_d[i] = '0;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pins_q   <= pins_d;
      start_q  <= wrap;
      speeds_q <= speeds_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, speeds_q, start_q, pins_q};

  // A stalled result must block the pipeline
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !advance)
    else $error("item advanced over a stalled result");

  // A wrap leaves the counter at zero
  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && wrap |=> count_q == '0)
    else $error("counter not cleared on wrap");

  // Only tick items move the counter or raise period_start
  a_cmd_no_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_q != MODE_TICK) |=> $stable(count_q) && !start_q)
    else $error("command item touched the period counter");

  // Every item moved into the result register shows as a valid result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result missing after advance");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the four-channel ESC pulse generator
// Drives tick, set, alter and stop items on the input stream and predicts
// every result item: pin levels, period-start flag and the four speeds. Runs
// directed items first, then random items over several register settings,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import qesc_pkg::*;

  localparam int unsigned ResetCycles    = 10;
  localparam int unsigned SettleCycles   = 4;     // input and result registers plus margin
  localparam int unsigned PhaseItems     = 90;
  localparam int unsigned PhaseCount     = 8;
  // Slowest run: ~750 items, each with up to a pick_gap gap and a pick_gap stall
  localparam int unsigned CycleLimit     = 300000;

  // One input item; val[0] is motor 0
  typedef struct packed {
    mode_e                mode;
    logic [2:0]           target;
    logic [3:0][15:0]     val;
  } esc_item_t;

  // One result item; speed[0] is motor 0
  typedef struct packed {
    logic [3:0][15:0] speed;
    logic             wrap;
    logic [3:0]       pins;
  } esc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // value_a[15:0], value_b[31:16], value_c[47:32], value_d[63:48],
  // stop_target[66:64], zero fill
  logic [71:0] s_axis_tdata_i;
  // mode[1:0]
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // pin_levels[3:0], period_start[4], speed_a[20:5], speed_b[36:21],
  // speed_c[52:37], speed_d[68:53], zero fill
  logic [71:0] m_axis_tdata_o;

  // Shadow of the generator: registers, setpoints, compares, counter, pins
  logic [15:0] period_ticks, min_ticks, max_ticks;
  logic [15:0] setpoint [4];
  logic [15:0] compare [4];
  logic [15:0] period_count;
  logic [3:0]  pin_state;

  esc_result_t pin_speed_q [$];   // results still owed by the block
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          tx_gaps     = 1'b1;
  bit          rx_stalls   = 1'b1;

  quad_esc_pulse_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Return the shadow to its state after reset
  function automatic void reset_shadow();
    period_ticks = PeriodTicksReset;
    min_ticks    = MinTicksReset;
    max_ticks    = MaxTicksReset;
    for (int i = 0; i < 4; i++) begin
      setpoint[i] = MinTicksReset;
      compare[i]  = MinTicksReset;
    end
    period_count = '0;
    pin_state    = '1;
  endfunction

  // Apply one item to the shadow and return the result it must produce
  function automatic esc_result_t advance_pulse_state(input esc_item_t it);
    esc_result_t r;
    logic [16:0] nxt;
    int          top;
    int          v;
    int          s;
    r.wrap = 1'b0;
    top    = int'(max_ticks) - int'(min_ticks);
    case (it.mode)
      MODE_TICK: begin
        // Wrap on reaching the period or on running out of counter bits
        nxt = {1'b0, period_count} + 17'd1;
        if (nxt[16] || nxt[15:0] >= period_ticks) begin
          nxt       = '0;
          r.wrap    = 1'b1;
          pin_state = '1;
          for (int i = 0; i < 4; i++) compare[i] = setpoint[i];
        end
        period_count = nxt[15:0];
        for (int i = 0; i < 4; i++)
          if (compare[i] == period_count) pin_state[i] = 1'b0;
      end
      MODE_SET: begin
        for (int i = 0; i < 4; i++) begin
          v = int'($signed(it.val[i]));
          if (v == -1) continue;               // leave this motor alone
          if (v < 0)        setpoint[i] = min_ticks;
          else if (v > top) setpoint[i] = max_ticks;
          else              setpoint[i] = 16'(v + int'(min_ticks));
        end
      end
      MODE_ALTER: begin
        for (int i = 0; i < 4; i++) begin
          v = int'($signed(it.val[i]));
          if (v == 0) continue;
          // Lower clamp first, then upper, even with max below min
          s = int'(setpoint[i]) + v;
          if (s < int'(min_ticks))      setpoint[i] = min_ticks;
          else if (s > int'(max_ticks)) setpoint[i] = max_ticks;
          else                          setpoint[i] = 16'(s);
        end
      end
      default: begin
        if (it.target == StopAll)
          for (int i = 0; i < 4; i++) setpoint[i] = min_ticks;
        else if (it.target < StopAll)
          setpoint[it.target[1:0]] = min_ticks;
        // targets above stop-all are ignored
      end
    endcase
    r.pins = pin_state;
    for (int i = 0; i < 4; i++) r.speed[i] = setpoint[i] - min_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic esc_item_t mk_item(input mode_e m, input int a, input int b,
                                        input int c, input int d,
                                        input logic [2:0] tgt);
    esc_item_t it;
    it.mode   = m;
    it.target = tgt;
    it.val[0] = 16'(a);
    it.val[1] = 16'(b);
    it.val[2] = 16'(c);
    it.val[3] = 16'(d);
    return it;
  endfunction

  // Bias values towards the span between min and max so clamps both hit and miss
  function automatic logic [15:0] pick_value(input mode_e m);
    int span;
    span = int'(max_ticks) - int'(min_ticks);
    if (span < 4) span = 4;
    else if (span > 30000) span = 30000;
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      3: return 16'($urandom);
      default: begin
        if (m == MODE_ALTER) return 16'($urandom_range(0, 2 * span) - span);
        return 16'($urandom_range(0, span + 2));
      end
    endcase
  endfunction

  function automatic esc_item_t random_item();
    esc_item_t it;
    int        roll;
    roll    = $urandom_range(0, 19);
    it.mode = (roll < 11) ? MODE_TICK : (roll < 14) ? MODE_SET :
              (roll < 17) ? MODE_ALTER : MODE_STOP;
    for (int i = 0; i < 4; i++) it.val[i] = pick_value(it.mode);
    it.target = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
    return it;
  endfunction

  // Present one item, hold it until accepted, then log its expected result
  task automatic send_item(input esc_item_t it);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, it.target, it.val};
    s_axis_tuser_i  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pin_speed_q.push_back(advance_pulse_state(it));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pin_speed_q.size() != 0);
  endtask

  // Drain, then let the pipeline empty out completely
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only call while idle
  task automatic write_config(input logic [15:0] period, input logic [15:0] lo,
                              input logic [15:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_PERIOD_TICKS;
    cfg_wdata_i <= period;
    @(posedge clk_i);
    cfg_addr_i  <= REG_MIN_TICKS;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_TICKS;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    period_ticks = period;
    min_ticks    = lo;
    max_ticks    = hi;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: counter at zero, pins high, setpoints at the reset minimum
  task automatic test_reset_values();
    send_item(mk_item(MODE_TICK, 0, 0, 0, 0, 3'd0));
    send_item(mk_item(MODE_SET, -1, -1, -1, -1, 3'd0));
  endtask

  // Short period so wraps and falling pins show up within a few ticks
  task automatic test_directed_sequence();
    settle();
    write_config(16'd6, 16'd2, 16'd5);
    // zero, top of range, leave alone, most negative
    send_item(mk_item(MODE_SET, 0, 3, -1, -32768, 3'd0));
    // above range, just above top, other negative, in range
    send_item(mk_item(MODE_SET, 32767, 4, -2, 1, 3'd7));
    // Run through one wrap and into the next period; value fields are ignored
    for (int i = 0; i < 9; i++) send_item(mk_item(MODE_TICK, -1, -1, -1, -1, 3'd7));
    // Deltas: step up, step down, zero, huge positive; then huge negative
    send_item(mk_item(MODE_ALTER, 1, -1, 0, 32767, 3'd0));
    send_item(mk_item(MODE_ALTER, -32768, 0, 1, -1, 3'd0));
    // Single stop, stop all, and targets beyond stop-all that must be ignored
    send_item(mk_item(MODE_STOP, 0, 0, 0, 0, 3'd1));
    send_item(mk_item(MODE_SET, 2, 2, 2, 2, 3'd0));
    send_item(mk_item(MODE_STOP, 0, 0, 0, 0, StopAll));
    send_item(mk_item(MODE_SET, 1, 3, 0, 2, 3'd0));
    send_item(mk_item(MODE_STOP, 0, 0, 0, 0, 3'd5));
    send_item(mk_item(MODE_STOP, 0, 0, 0, 0, 3'd7));
  endtask

  // Max below min; raising min above the old setpoints also wraps the speeds
  task automatic test_inverted_limits();
    settle();
    write_config(16'd5, 16'd9, 16'd4);
    send_item(mk_item(MODE_STOP, 0, 0, 0, 0, 3'd6));
    send_item(mk_item(MODE_SET, 0, 7, -5, -1, 3'd0));
    send_item(mk_item(MODE_ALTER, 1, -1, 0, -32768, 3'd0));
    for (int i = 0; i < 3; i++) send_item(mk_item(MODE_TICK, 0, 0, 0, 0, 3'd0));
  endtask

  // Random items over several settings, register extremes among them
  task automatic test_random_phases();
    logic [15:0] periods [PhaseCount] = '{16'd12, 16'd2, 16'd30, 16'd40,
                                          16'd25, 16'd65535, 16'd64, 16'd16};
    logic [15:0] mins    [PhaseCount] = '{16'd3, 16'd1, 16'd1, 16'd65535,
                                          16'd20, 16'd1500, 16'd10, 16'd5};
    logic [15:0] maxes   [PhaseCount] = '{16'd9, 16'd1, 16'd65535, 16'd1,
                                          16'd5, 16'd3000, 16'd50, 16'd12};
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      write_config(periods[p], mins[p], maxes[p]);
      // Last phase runs flat out on both streams
      tx_gaps   = (p != PhaseCount - 1);
      rx_stalls = (p != PhaseCount - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        // Hold the sender once until every result has come back
        if (p == 3 && n == PhaseItems / 2) drain();
        send_item(random_item());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // ---------------------------------------------------------------------------

  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    esc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pin_speed_q.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        want = pin_speed_q.pop_front();
        check_field("pin_levels",   16'(want.pins),  16'(m_axis_tdata_o[3:0]));
        check_field("period_start", 16'(want.wrap),  16'(m_axis_tdata_o[4]));
        check_field("speed_a",      want.speed[0],   m_axis_tdata_o[20:5]);
        check_field("speed_b",      want.speed[1],   m_axis_tdata_o[36:21]);
        check_field("speed_c",      want.speed[2],   m_axis_tdata_o[52:37]);
        check_field("speed_d",      want.speed[3],   m_axis_tdata_o[68:53]);
      end
    end
  end

  // Watchdog: a run that hangs or loses results ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= REG_PERIOD_TICKS;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= MODE_TICK;
    reset_shadow();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_sequence();
    test_inverted_limits();
    test_random_phases();
    settle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qesc_pkg.sv
rtl/qesc_chan.sv
rtl/quad_esc_pulse_generator.sv
dv/tb.sv
